// ===== hw/rtl/sha256_pkg.sv =====
// Package: SHA-256 payload types, controller command/status types, constants.
`default_nettype none
package sha256_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} sha_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} sha_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_PAD,
		ST_PAD_COMP,
		ST_EMIT
	} sha_state_t;

	// Controller to datapath
	typedef struct packed {
		logic       write_byte;   // store input byte, bump counters
		logic       pad_write;    // write one padding byte at the fill position
		logic       len_write;    // padding byte comes from the bit length
		logic       clear_fill;   // fill count back to zero
		logic       start_comp;   // load round registers from chaining value
		logic       round_en;     // run one round
		logic       finish_comp;  // add round registers into chaining value
		logic       reload_iv;    // restart: initial value, counters cleared
		logic       latch_len;    // capture message bit length
	} sha_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic       block_full;   // next byte is the last one of the block
		logic [5:0] fill;
		logic       last_round;
	} sha_stat_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
		32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
		32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
		32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
		32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
		32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
		32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
		32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
		32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sha256_datapath.sv =====
// Datapath: block buffer, counters, message schedule, round unit, chaining value.
`default_nettype none
module sha256_datapath
	import sha256_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire sha_cmd_t    cmd,
	input  wire logic [7:0]  data_byte,
	input  wire logic [2:0]  rd_index,
	output sha_stat_t        stat,
	output logic [31:0]      cv_word
);
	// block buffer kept as 16 big-endian words, byte lanes written one at a time
	logic [31:0] buf_q [16];
	logic [5:0]  fill_q;
	logic [60:0] count_q;
	logic [63:0] bits_q;
	logic [31:0] w_q [16];
	logic [31:0] r_q [8];
	logic [31:0] cv_q [8];
	logic [5:0]  round_q;

	// Length byte for the current fill position (56 = most significant)
	logic [7:0] pad_byte;
	logic [7:0] wr_byte;
	logic [4:0] lane_lsb;
	assign pad_byte = bits_q[{~fill_q[2:0], 3'b111} -: 8];
	assign lane_lsb = {~fill_q[1:0], 3'b000};

	always_comb begin
		if (cmd.write_byte)
			wr_byte = data_byte;
		else if (cmd.latch_len)
			wr_byte = PAD_BYTE;
		else if (cmd.len_write)
			wr_byte = pad_byte;
		else
			wr_byte = 8'h00;
	end

	// Block buffer write and fill counter
	always_ff @(posedge clk) begin
		if (cmd.write_byte || cmd.pad_write)
			buf_q[fill_q[5:2]][lane_lsb +: 8] <= wr_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
		end else if (cmd.reload_iv) begin
			fill_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.write_byte)
				count_q <= count_q + 61'd1;
			if (cmd.clear_fill)
				fill_q <= '0;
			else if (cmd.write_byte || cmd.pad_write)
				fill_q <= fill_q + 6'd1;
		end
	end

	// Bit length, captured with the 0x80 byte
	always_ff @(posedge clk) begin
		if (cmd.latch_len)
			bits_q <= {count_q, 3'b000};
	end

	// Schedule word for this round
	logic [31:0] w_new, w15, w2, s0w, s1w;
	logic [3:0]  slot;
	assign slot = round_q[3:0];
	assign w15  = w_q[4'(slot + 4'd1)];
	assign w2   = w_q[4'(slot + 4'd14)];
	assign s0w  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
	assign s1w  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
	always_comb begin
		if (round_q < 6'd16)
			w_new = buf_q[slot];
		else
			w_new = w_q[slot] + s0w + w_q[4'(slot + 4'd9)] + s1w;
	end

	// One compression round
	logic [31:0] t1, t2, ch, maj, e1, e0;
	assign e1  = rotr(r_q[4], 6) ^ rotr(r_q[4], 11) ^ rotr(r_q[4], 25);
	assign ch  = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
	assign t1  = r_q[7] + e1 + ch + ROUND_K[round_q] + w_new;
	assign e0  = rotr(r_q[0], 2) ^ rotr(r_q[0], 13) ^ rotr(r_q[0], 22);
	assign maj = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);
	assign t2  = e0 + maj;

	always_ff @(posedge clk) begin
		if (cmd.start_comp) begin
			for (int i = 0; i < 8; i++)
				r_q[i] <= cv_q[i];
		end else if (cmd.round_en) begin
			w_q[slot] <= w_new;
			r_q[7] <= r_q[6];
			r_q[6] <= r_q[5];
			r_q[5] <= r_q[4];
			r_q[4] <= r_q[3] + t1;
			r_q[3] <= r_q[2];
			r_q[2] <= r_q[1];
			r_q[1] <= r_q[0];
			r_q[0] <= t1 + t2;
		end
	end

	// Round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			round_q <= '0;
		else if (cmd.start_comp)
			round_q <= '0;
		else if (cmd.round_en)
			round_q <= round_q + 6'd1;
	end

	// Chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				cv_q[i] <= INIT_HASH[i];
		end else if (cmd.reload_iv) begin
			for (int i = 0; i < 8; i++)
				cv_q[i] <= INIT_HASH[i];
		end else if (cmd.finish_comp) begin
			for (int i = 0; i < 8; i++)
				cv_q[i] <= cv_q[i] + r_q[i];
		end
	end

	assign cv_word         = cv_q[rd_index];
	assign stat.fill       = fill_q;
	assign stat.block_full = (fill_q == 6'd63);
	assign stat.last_round = (round_q == 6'd63);
endmodule
`default_nettype wire

// ===== hw/rtl/sha256_ctrl.sv =====
// Controller: sequences byte intake, compression, padding and digest output.
`default_nettype none
module sha256_ctrl
	import sha256_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire logic      in_bv,
	input  wire logic      in_eom,
	input  wire sha_stat_t stat,
	output sha_cmd_t       cmd,
	output logic           out_valid,
	input  wire logic      out_ready,
	output logic [2:0]     rd_index
);
	sha_state_t state_q, state_d;
	logic       comp_q;     // round-register load pending
	logic       pad_q;      // message end pending after current compression
	logic [2:0] idx_q;
	logic       comp_d, pad_d;
	logic       first_pad_q, first_pad_d;
	logic       len_blk_q, len_blk_d;    // padding block in progress ends with the length
	logic       last_blk_q, last_blk_d;  // block being compressed carries the length
	logic       len_blk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pad_q       <= 1'b0;
			idx_q       <= '0;
			first_pad_q <= 1'b0;
			comp_q      <= 1'b0;
			len_blk_q   <= 1'b0;
			last_blk_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			pad_q       <= pad_d;
			first_pad_q <= first_pad_d;
			comp_q      <= comp_d;
			len_blk_q   <= len_blk_d;
			last_blk_q  <= last_blk_d;
			if (state_q == ST_EMIT && out_ready)
				idx_q <= idx_q + 3'd1;
		end
	end

	// 0x80 at byte 56 or later pushes the length into one more block
	assign len_blk = first_pad_q ? (stat.fill < LEN_POS) : len_blk_q;

	always_comb begin
		state_d     = state_q;
		pad_d       = pad_q;
		first_pad_d = first_pad_q;
		comp_d      = comp_q;
		len_blk_d   = len_blk_q;
		last_blk_d  = last_blk_q;
		cmd         = '0;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				last_blk_d = 1'b0;
				if (in_valid) begin
					cmd.write_byte = in_bv;
					pad_d = in_eom;
					first_pad_d = 1'b1;
					if (in_bv && stat.block_full) begin
						cmd.clear_fill = 1'b1;
						state_d = ST_COMP;
						comp_d = 1'b1;
					end else if (in_eom) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_COMP: begin
				// load round registers first, then run 64 rounds
				if (comp_q) begin
					cmd.start_comp = 1'b1;
					comp_d = 1'b0;
				end else begin
					cmd.round_en = 1'b1;
					if (stat.last_round)
						state_d = ST_PAD_COMP;
				end
			end
			ST_PAD_COMP: begin
				cmd.finish_comp = 1'b1;
				if (pad_q)
					state_d = ST_PAD;
				else if (last_blk_q)
					state_d = ST_EMIT;
				else
					state_d = ST_IDLE;
			end
			ST_PAD: begin
				cmd.pad_write = 1'b1;
				cmd.latch_len = first_pad_q;
				cmd.len_write = len_blk && (stat.fill >= LEN_POS);
				first_pad_d = 1'b0;
				len_blk_d = len_blk;
				if (stat.fill == 6'd63) begin
					cmd.clear_fill = 1'b1;
					comp_d = 1'b1;
					state_d = ST_COMP;
					// without the length here, one more padding block follows
					pad_d = !len_blk;
					last_blk_d = len_blk;
					len_blk_d = 1'b1;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready && idx_q == 3'd7) begin
					cmd.reload_iv = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign rd_index = idx_q;
endmodule
`default_nettype wire

// ===== hw/rtl/sha256_stream_hasher.sv =====
// Top level: SHA-256 byte-stream hasher with digest word output.
`default_nettype none
// Takes one byte per transfer; a byte that fills a 64-byte block starts the
// 64-round compression, one round per cycle plus a load and a final add
// (no input is taken during it). An end-of-message transfer writes the
// padding one byte per cycle, runs one or two more compressions and then
// presents the eight digest words, word 0 first, after which the initial
// hash value is reloaded for the next message. A single round unit is
// shared by all rounds.
module sha256_stream_hasher
	import sha256_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire sha_in_t in_data,
	output logic         out_valid,
	input  wire logic    out_ready,
	output sha_out_t     out_data
);
	sha_cmd_t    cmd;
	sha_stat_t   stat;
	logic [2:0]  rd_index;
	logic [31:0] cv_word;

	sha256_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_bv     (in_data.byte_valid),
		.in_eom    (in_data.end_of_message),
		.stat      (stat),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rd_index  (rd_index)
	);

	sha256_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (in_data.data_byte),
		.rd_index  (rd_index),
		.stat      (stat),
		.cv_word   (cv_word)
	);

	assign out_data.digest_word = cv_word;
	assign out_data.word_index  = rd_index;
	assign out_data.last_word   = (rd_index == 3'd7);
endmodule
`default_nettype wire
